// ===== hw/rtl/texel_owner_best_barycentric_macros.svh =====
// assertion macros for the texel ownership table
// used by texel_owner_best_barycentric; expects i_clk and i_rst_n in scope
`ifndef TEXEL_OWNER_BEST_BARYCENTRIC_MACROS_SVH
`define TEXEL_OWNER_BEST_BARYCENTRIC_MACROS_SVH

// same-cycle implication, checked out of reset
`define TOB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tob_pkg.sv =====
// shared types and constants for the texel ownership table
// no dependencies
package tob_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned WGT_W  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TOL   = 2'd1;

    localparam logic [8:0] ROW_WIDTH_RST = 9'd256;
    localparam logic [7:0] MIN_TOL_RST   = 8'd3;

    typedef struct packed {
        logic [7:0]       texel_x;
        logic [7:0]       texel_y;
        logic [WGT_W-1:0] weight_a;
        logic [WGT_W-1:0] weight_b;
        logic [WGT_W-1:0] weight_c;
    } t_in_beat;

    typedef struct packed {
        logic              accepted;
        logic              was_used;
        logic [ADDR_W-1:0] texel_index;
    } t_out_beat;

    // one table entry
    typedef struct packed {
        logic             used;
        logic [WGT_W-1:0] wmin;
        logic [WGT_W-1:0] wmax;
    } t_texel_rec;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] addr;
    } t_fold_req;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] slot;
    } t_fold_rsp;

endpackage

// ===== hw/rtl/tob_ram.sv =====
// generic single-write, single-read synchronous ram, registered read
// no dependencies
module tob_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65536
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tob_addr_fold.sv =====
// folds a 16-bit texel address into the table range by reciprocal multiplication
// four registered steps from start to done; depends on tob_pkg
module tob_addr_fold #(
    parameter int unsigned DEPTH = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tob_pkg::t_fold_req i_req,
    output tob_pkg::t_fold_rsp o_rsp
);

    // floor(2^32 / DEPTH): the quotient estimate is exact or one short
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(DEPTH));
    localparam logic [tob_pkg::ADDR_W-1:0] DIVISOR = tob_pkg::ADDR_W'(DEPTH);

    logic                       r_addr_v, r_quot_v, r_rem_v, r_done;
    logic [tob_pkg::ADDR_W-1:0] r_addr, r_addr_q, r_quot, r_rem, r_slot;
    logic [tob_pkg::ADDR_W-1:0] n_quot, n_rem, n_slot;
    logic [47:0]                prod;

    assign prod   = {32'd0, r_addr} * {15'd0, RECIP};
    assign n_quot = prod[47:32];
    // quotient times divisor never exceeds the address, so 16 bits hold it
    assign n_rem  = r_addr_q - r_quot * DIVISOR;
    assign n_slot = (r_rem >= DIVISOR) ? (r_rem - DIVISOR) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_v <= 1'b0;
            r_quot_v <= 1'b0;
            r_rem_v  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_addr_v <= i_req.start;
            r_quot_v <= r_addr_v;
            r_rem_v  <= r_quot_v;
            r_done   <= r_rem_v;
        end
        if (i_req.start) begin
            r_addr <= i_req.addr;
        end
        r_addr_q <= r_addr;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_slot   <= n_slot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.slot = r_slot;

endmodule

// ===== hw/rtl/texel_owner_best_barycentric.sv =====
// top level of the texel ownership table for lightmap baking
// depends on tob_pkg, tob_ram, tob_addr_fold and the assertion macro header
//
// Each input beat offers a texel and three Q1.15 weights; one result beat comes
// back per offer. The table lives in one synchronous ram read, compared and
// written back per offer, one offer at a time. With MAX_WIDTH*MAX_HEIGHT of 65536
// or more an accepted offer goes through the READ and CMP states, the result beat
// is registered as CMP hands back to IDLE, and the next offer can be taken in
// IDLE; a smaller table first folds the address into range with the reciprocal
// reduction in tob_addr_fold (FOLD state) before READ. A result beat held by the
// receiver holds the next compare back. After reset a clearing pass writes every
// reachable entry, during which no offer is taken; configuration writes are taken
// at any time.
`include "texel_owner_best_barycentric_macros.svh"

module texel_owner_best_barycentric #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tob_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tob_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tob_pkg::t_in_beat                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tob_pkg::t_out_beat                o_out
);

    localparam int unsigned DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_SPAN = 1 << tob_pkg::ADDR_W;
    localparam int unsigned MEM_DEPTH = (DEPTH > ADDR_SPAN) ? ADDR_SPAN : DEPTH;
    localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam bit          NEED_FOLD = (DEPTH < ADDR_SPAN);
    localparam int unsigned REC_W     = $bits(tob_pkg::t_texel_rec);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FOLD  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;

    function automatic logic [tob_pkg::WGT_W-1:0] lo3(
        input logic [tob_pkg::WGT_W-1:0] a,
        input logic [tob_pkg::WGT_W-1:0] b,
        input logic [tob_pkg::WGT_W-1:0] c
    );
        logic [tob_pkg::WGT_W-1:0] m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        return m;
    endfunction

    function automatic logic [tob_pkg::WGT_W-1:0] hi3(
        input logic [tob_pkg::WGT_W-1:0] a,
        input logic [tob_pkg::WGT_W-1:0] b,
        input logic [tob_pkg::WGT_W-1:0] c
    );
        logic [tob_pkg::WGT_W-1:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

    logic [2:0]                r_state, n_state;
    logic [AW-1:0]             r_clr, n_clr;
    logic [8:0]                r_row_width;
    logic [7:0]                r_min_tol;
    logic [tob_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [tob_pkg::ADDR_W-1:0] r_slot, n_slot;
    logic [tob_pkg::WGT_W-1:0] r_wmin, n_wmin;
    logic [tob_pkg::WGT_W-1:0] r_wmax, n_wmax;
    logic                      r_out_valid, n_out_valid;
    tob_pkg::t_out_beat        r_out, n_out;

    logic                      in_acc;
    logic                      can_emit;
    logic                      cmp_fire;
    logic [16:0]               prod;
    logic [16:0]               lin_addr;
    tob_pkg::t_fold_req        fold_req;
    tob_pkg::t_fold_rsp        fold_rsp;
    tob_pkg::t_texel_rec       rd_rec;
    tob_pkg::t_texel_rec       wr_rec;
    logic [REC_W-1:0]          ram_rdata;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [tob_pkg::WGT_W-1:0] diff;
    logic                      take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= tob_pkg::ROW_WIDTH_RST;
            r_min_tol   <= tob_pkg::MIN_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tob_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_data;
                tob_pkg::CFG_MIN_TOL:   r_min_tol   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign can_emit   = !r_out_valid || !i_out_stall;
    assign cmp_fire   = (r_state == S_CMP) && can_emit;

    // row-major address, wrapped to 16 bits
    assign prod     = {9'd0, i_in.texel_y} * {8'd0, r_row_width};
    assign lin_addr = prod + {9'd0, i_in.texel_x};

    assign fold_req.start = in_acc && NEED_FOLD;
    assign fold_req.addr  = lin_addr[tob_pkg::ADDR_W-1:0];

    tob_addr_fold #(
        .DEPTH (DEPTH)
    ) u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fold_req),
        .o_rsp   (fold_rsp)
    );

    assign rd_rec = tob_pkg::t_texel_rec'(ram_rdata);

    // stored extremes against the offer
    always_comb begin
        diff = (r_wmin > rd_rec.wmin) ? (r_wmin - rd_rec.wmin) : (rd_rec.wmin - r_wmin);
        if (!rd_rec.used) begin
            take = 1'b1;
        end else if (diff > {8'd0, r_min_tol}) begin
            take = r_wmin > rd_rec.wmin;
        end else begin
            take = r_wmax < rd_rec.wmax;
        end
    end

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_slot[AW-1:0];
        wr_rec.used = 1'b1;
        wr_rec.wmin = r_wmin;
        wr_rec.wmax = r_wmax;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            wr_rec    = '0;
        end else if (cmp_fire && take) begin
            ram_we = 1'b1;
        end
    end

    tob_ram #(
        .WIDTH (REC_W),
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_rec),
        .i_raddr (r_slot[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_slot      = r_slot;
        n_wmin      = r_wmin;
        n_wmax      = r_wmax;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_addr  = lin_addr[tob_pkg::ADDR_W-1:0];
                    n_slot  = lin_addr[tob_pkg::ADDR_W-1:0];
                    n_wmin  = lo3(i_in.weight_a, i_in.weight_b, i_in.weight_c);
                    n_wmax  = hi3(i_in.weight_a, i_in.weight_b, i_in.weight_c);
                    n_state = NEED_FOLD ? S_FOLD : S_READ;
                end
            end
            S_FOLD: begin
                if (fold_rsp.done) begin
                    n_slot  = fold_rsp.slot;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (can_emit) begin
                    n_out.accepted    = take;
                    n_out.was_used    = rd_rec.used;
                    n_out.texel_index = r_addr;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_addr <= n_addr;
        r_slot <= n_slot;
        r_wmin <= n_wmin;
        r_wmax <= n_wmax;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TOB_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != S_IDLE, "still idle after accept")
    `TOB_ASSERT_NOW(a_write_ok, ram_we, r_state == S_CLEAR || r_state == S_CMP, "stray table write")
    `TOB_ASSERT_NEXT(a_result_out, cmp_fire, r_out_valid && r_state == S_IDLE, "result missing")
    `TOB_ASSERT_NOW(a_fold_done_in_fold, fold_rsp.done, r_state == S_FOLD, "stray fold done")

endmodule
